FILE: rtl/rpf_pkg.sv
// Shared constants, types and helper functions of the RGB pixel filter.
`default_nettype none
package rpf_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WD_W  = $clog2(MAX_WIDTH + 1);
	localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 5);
	localparam int S_W   = ((WD_W > ROW_W) ? WD_W : ROW_W) + 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_DIM_W  = 12;

	localparam int LINE_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_FACTOR,
		REG_WIDTH,
		REG_HEIGHT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_DARKEN,
		MODE_BRIGHTEN,
		MODE_NEGATIVE,
		MODE_GRAYSCALE,
		MODE_BINARIZE,
		MODE_SOBEL,
		MODE_GAUSS_LAP,
		MODE_PASS
	} mode_t;

	// [0] red, [1] green, [2] blue
	typedef logic [2:0][7:0] rgb_t;
	// [y][x] rows top to bottom, columns left to right
	typedef logic [2:0][2:0][2:0][7:0] win_t;

	typedef struct packed {
		rgb_t             pix;
		logic             pt_ok;
		logic             pt_end;
		logic             s_c0;
		logic             s_g1;
		logic             s_g2;
		logic             b_ok;
		logic             b_end;
		logic             l_c0;
		logic             l_g1;
		logic             l_g2;
		logic             l_ok;
		logic             l_end;
		logic [COL_W-1:0] s_addr;
		logic [COL_W-1:0] l_addr;
	} desc_t;

	function automatic logic [7:0] clamp8(input logic signed [12:0] x);
		logic [7:0] y;
		if (x < 13'sd0)
			y = 8'd0;
		else if (x > 13'sd255)
			y = 8'd255;
		else
			y = x[7:0];
		return y;
	endfunction

	// floor(s / 3) for s up to 765 by reciprocal multiply
	function automatic logic [7:0] div3(input logic [9:0] s);
		logic [19:0] prod;
		prod = 20'(s) * 20'd683;
		return prod[18:11];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rpf_if.sv
// Stream channel interfaces for pixels in and treated pixels out.
`default_nettype none
interface rpf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic       frame_start;
	modport source(output valid, output red_in, output green_in, output blue_in,
		output frame_start, input ready);
	modport sink(input valid, input red_in, input green_in, input blue_in,
		input frame_start, output ready);
endinterface

interface rpf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_end;
	modport source(output valid, output red_out, output green_out, output blue_out,
		output frame_end, input ready);
	modport sink(input valid, input red_out, input green_out, input blue_out,
		input frame_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/rpf_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/rpf_front.sv
// Front end: raster position tracking and per-beat classification.
`default_nettype none
module rpf_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	rpf_in_if.sink                      pix_in,
	input  wire logic [rpf_pkg::WD_W-1:0] w_eff,
	input  wire logic [rpf_pkg::HT_W-1:0] h_eff,
	input  wire logic                   q_full,
	output logic                        q_push,
	output rpf_pkg::desc_t              q_desc
);
	import rpf_pkg::*;

	localparam logic signed [S_W-1:0] ZERO = '0;
	localparam logic signed [S_W-1:0] ONE  = S_W'(1);
	localparam logic signed [S_W-1:0] TWO  = S_W'(2);
	localparam logic signed [S_W-1:0] FOUR = S_W'(4);

	logic [ROW_W-1:0] row_q, r;
	logic [COL_W-1:0] col_q, c;
	logic signed [S_W-1:0] rs, cs, ws, hs, si, sj, li, lj;
	logic c0, lc0;

	assign pix_in.ready = !q_full;
	assign q_push       = pix_in.valid && !q_full;

	always_comb begin
		r   = pix_in.frame_start ? '0 : row_q;
		c   = pix_in.frame_start ? '0 : col_q;
		rs  = S_W'(r);
		cs  = S_W'(c);
		ws  = S_W'(w_eff);
		hs  = S_W'(h_eff);
		c0  = (c == '0);
		// window center of the first stage lags by one row and one pixel
		si  = c0 ? rs - TWO : rs - ONE;
		sj  = c0 ? ws - ONE : cs - ONE;
		lc0 = (sj == ZERO);
		li  = lc0 ? si - TWO : si - ONE;
		lj  = lc0 ? ws - ONE : sj - ONE;

		q_desc.pix    = {pix_in.blue_in, pix_in.green_in, pix_in.red_in};
		q_desc.pt_ok  = rs < hs;
		q_desc.pt_end = (rs == hs - ONE) && (cs == ws - ONE);
		q_desc.s_c0   = c0;
		q_desc.s_g1   = rs >= ONE;
		q_desc.s_g2   = rs >= TWO;
		q_desc.b_ok   = (si >= ZERO) && (si < hs);
		q_desc.b_end  = (si == hs - ONE) && (sj == ws - ONE);
		q_desc.l_c0   = lc0;
		q_desc.l_g1   = si >= ONE;
		q_desc.l_g2   = si >= TWO;
		q_desc.l_ok   = (li >= ZERO) && (li < hs);
		q_desc.l_end  = (li == hs - ONE) && (lj == ws - ONE);
		q_desc.s_addr = c;
		q_desc.l_addr = sj[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (q_push) begin
			if (cs + ONE < ws) begin
				col_q <= c + 1'b1;
				row_q <= r;
			end else begin
				col_q <= '0;
				// park the row counter well past the frame
				row_q <= (rs < hs + FOUR) ? r + 1'b1 : r;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rpf_queue.sv
// Two-entry queue between the front end and the filter pipeline.
`default_nettype none
module rpf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  rpf_pkg::desc_t      push_data,
	output logic                full,
	input  wire logic           pop,
	output logic                head_vld,
	output rpf_pkg::desc_t      head_data
);
	import rpf_pkg::*;

	desc_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign head_vld  = (cnt_q != 2'd0);
	assign head_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end
endmodule
`default_nettype wire

FILE: rtl/rpf_back.sv
// Filter pipeline: two window stages with line buffers, point ops, output register.
`default_nettype none
module rpf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_vld,
	input  rpf_pkg::desc_t      q_desc,
	output logic                q_pop,
	input  rpf_pkg::mode_t      mode,
	input  wire logic [7:0]     factor,
	rpf_out_if.source           pix_out
);
	import rpf_pkg::*;

	logic en;

	// stage 1: source line buffer and window
	logic              vld_s1, byp_s1;
	desc_t             d_s1;
	logic [LINE_W-1:0] rd1, fwd1_q;
	rgb_t              v1, row0_1, row1_1;
	rgb_t [2:0]        col1;
	win_t              swin_q, sres;

	// stage 2: blur and sobel sums
	logic  vld_s2;
	desc_t d_s2;
	win_t  sres_s2;
	rgb_t  blur2, sob2;

	// stage 3: blurred line buffer and window
	logic              vld_s3, byp_s3;
	desc_t             d_s3;
	rgb_t              blur_s3, sob_s3;
	logic [LINE_W-1:0] rd2, fwd2_q;
	rgb_t              row0_3, row1_3;
	rgb_t [2:0]        col3;
	win_t              lwin_q, lres;

	// stage 4: laplacian, point ops, selection
	logic  vld_s4;
	desc_t d_s4;
	rgb_t  top_s4, left_s4, mid_s4, right_s4, bot_s4, sob_s4;
	rgb_t  lap4, pt4, res4;
	logic  prod4, fend4;

	logic out_vld_q, out_end_q;
	rgb_t out_pix_q;

	assign en    = !out_vld_q || pix_out.ready;
	assign q_pop = en && q_vld;

	rpf_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_src_rows (
		.clk   (clk),
		.we    (en && vld_s1),
		.waddr (d_s1.s_addr),
		.wdata ({row0_1, v1}),
		.re    (en),
		.raddr (q_desc.s_addr),
		.rdata (rd1)
	);

	rpf_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_blur_rows (
		.clk   (clk),
		.we    (en && vld_s3),
		.waddr (d_s3.l_addr),
		.wdata ({row0_3, blur_s3}),
		.re    (en),
		.raddr (d_s2.l_addr),
		.rdata (rd2)
	);

	always_comb begin
		v1     = d_s1.pt_ok ? d_s1.pix : '0;
		// take the entry written on the same edge as this read
		row0_1 = byp_s1 ? fwd1_q[23:0] : rd1[23:0];
		row1_1 = byp_s1 ? fwd1_q[47:24] : rd1[47:24];
		col1[0] = d_s1.s_g2 ? row1_1 : '0;
		col1[1] = d_s1.s_g1 ? row0_1 : '0;
		col1[2] = v1;
		for (int y = 0; y < 3; y++) begin
			sres[y][0] = swin_q[y][1];
			sres[y][1] = swin_q[y][2];
			sres[y][2] = d_s1.s_c0 ? '0 : col1[y];
		end
	end

	always_comb begin
		logic [11:0]        bsum;
		logic [10:0]        vp, vn, hp, hn;
		logic signed [12:0] ver, hor;
		logic [7:0]         a, b;
		for (int k = 0; k < 3; k++) begin
			bsum = 12'(sres_s2[0][0][k]) + (12'(sres_s2[0][1][k]) << 1)
			     + 12'(sres_s2[0][2][k]) + (12'(sres_s2[1][0][k]) << 1)
			     + (12'(sres_s2[1][1][k]) << 2) + (12'(sres_s2[1][2][k]) << 1)
			     + 12'(sres_s2[2][0][k]) + (12'(sres_s2[2][1][k]) << 1)
			     + 12'(sres_s2[2][2][k]);
			blur2[k] = d_s2.b_ok ? clamp8(13'(bsum >> 3)) : '0;
			vp  = 11'(sres_s2[0][0][k]) + (11'(sres_s2[0][1][k]) << 1) + 11'(sres_s2[0][2][k]);
			vn  = 11'(sres_s2[2][0][k]) + (11'(sres_s2[2][1][k]) << 1) + 11'(sres_s2[2][2][k]);
			hp  = 11'(sres_s2[0][0][k]) + (11'(sres_s2[1][0][k]) << 1) + 11'(sres_s2[2][0][k]);
			hn  = 11'(sres_s2[0][2][k]) + (11'(sres_s2[1][2][k]) << 1) + 11'(sres_s2[2][2][k]);
			ver = 13'(vp) - 13'(vn);
			hor = 13'(hp) - 13'(hn);
			a   = clamp8(ver);
			b   = clamp8(hor);
			sob2[k] = (a >= b) ? a : b;
		end
	end

	always_comb begin
		row0_3  = byp_s3 ? fwd2_q[23:0] : rd2[23:0];
		row1_3  = byp_s3 ? fwd2_q[47:24] : rd2[47:24];
		col3[0] = d_s3.l_g2 ? row1_3 : '0;
		col3[1] = d_s3.l_g1 ? row0_3 : '0;
		col3[2] = blur_s3;
		for (int y = 0; y < 3; y++) begin
			lres[y][0] = lwin_q[y][1];
			lres[y][1] = lwin_q[y][2];
			lres[y][2] = d_s3.l_c0 ? '0 : col3[y];
		end
	end

	always_comb begin
		logic [9:0] sum;
		logic [7:0] mean;
		sum  = 10'(d_s4.pix[0]) + 10'(d_s4.pix[1]) + 10'(d_s4.pix[2]);
		mean = div3(sum);
		for (int k = 0; k < 3; k++) begin
			lap4[k] = clamp8((13'(mid_s4[k]) << 2) - 13'(top_s4[k]) - 13'(left_s4[k])
				- 13'(right_s4[k]) - 13'(bot_s4[k]));
			unique case (mode)
				MODE_DARKEN:    pt4[k] = clamp8(13'(d_s4.pix[k]) - 13'(factor));
				MODE_BRIGHTEN:  pt4[k] = clamp8(13'(d_s4.pix[k]) + 13'(factor));
				MODE_NEGATIVE:  pt4[k] = 8'd255 - d_s4.pix[k];
				MODE_GRAYSCALE: pt4[k] = mean;
				MODE_BINARIZE:  pt4[k] = (mean > 8'd128) ? 8'd255 : 8'd0;
				default:        pt4[k] = d_s4.pix[k];
			endcase
		end
		unique case (mode)
			MODE_SOBEL: begin
				res4  = sob_s4;
				prod4 = d_s4.b_ok;
				fend4 = d_s4.b_end;
			end
			MODE_GAUSS_LAP: begin
				res4  = lap4;
				prod4 = d_s4.l_ok;
				fend4 = d_s4.l_end;
			end
			default: begin
				res4  = pt4;
				prod4 = d_s4.pt_ok;
				fend4 = d_s4.pt_end;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			byp_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			byp_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
			swin_q    <= '0;
			lwin_q    <= '0;
		end else if (en) begin
			vld_s1    <= q_vld;
			byp_s1    <= vld_s1 && q_vld && (q_desc.s_addr == d_s1.s_addr);
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			byp_s3    <= vld_s3 && vld_s2 && (d_s2.l_addr == d_s3.l_addr);
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4 && prod4;
			if (vld_s1) begin
				for (int y = 0; y < 3; y++) begin
					swin_q[y][0] <= d_s1.s_c0 ? '0 : swin_q[y][1];
					swin_q[y][1] <= d_s1.s_c0 ? '0 : swin_q[y][2];
					swin_q[y][2] <= col1[y];
				end
			end
			if (vld_s3) begin
				for (int y = 0; y < 3; y++) begin
					lwin_q[y][0] <= d_s3.l_c0 ? '0 : lwin_q[y][1];
					lwin_q[y][1] <= d_s3.l_c0 ? '0 : lwin_q[y][2];
					lwin_q[y][2] <= col3[y];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1      <= q_desc;
			fwd1_q    <= {row0_1, v1};
			d_s2      <= d_s1;
			sres_s2   <= sres;
			d_s3      <= d_s2;
			blur_s3   <= blur2;
			sob_s3    <= sob2;
			fwd2_q    <= {row0_3, blur_s3};
			d_s4      <= d_s3;
			sob_s4    <= sob_s3;
			top_s4    <= lres[0][1];
			left_s4   <= lres[1][0];
			mid_s4    <= lres[1][1];
			right_s4  <= lres[1][2];
			bot_s4    <= lres[2][1];
			out_pix_q <= res4;
			out_end_q <= fend4;
		end
	end

	assign pix_out.valid     = out_vld_q;
	assign pix_out.red_out   = out_pix_q[0];
	assign pix_out.green_out = out_pix_q[1];
	assign pix_out.blue_out  = out_pix_q[2];
	assign pix_out.frame_end = out_end_q;
endmodule
`default_nettype wire

FILE: rtl/rgb_pixel_filter_stream_core.sv
// RGB pixel filter: raster stream in, treated pixel stream out.
//
// Pixels enter on pix_in in raster order, one beat per pixel; frame_start marks
// the first pixel of a frame. Treated pixels leave on pix_out with frame_end on
// the last pixel. Mode, factor and frame size are written over the cfg port by
// the host only while the block is idle; the block itself does not enforce it.
// Throughput: one beat per cycle in every mode while pix_out is ready. A beat
// passes through the queue, the filter pipeline and the output register before
// it reaches pix_out; in sobel mode the result for a pixel comes with the beat
// W+1 positions later and in gauss-laplace mode 2W+2 later, W being the width,
// so the host sends that many padding beats after the frame. Beats whose
// position falls outside the frame produce no output beat.
// The line buffers are two RAMs of MAX_WIDTH entries, one read and one write
// per cycle each; this sets the one-beat-per-cycle figure.
// Reset clears the position, the windows and the pipeline; the line buffers are
// not cleared and need no clearing pass. When pix_out stalls, the output register
// and pipeline hold, the two-entry queue takes beats until full, then pix_in.ready drops.
`default_nettype none
module rgb_pixel_filter_stream_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rpf_pkg::CFG_DATA_W-1:0] cfg_data,
	rpf_in_if.sink                             pix_in,
	rpf_out_if.source                          pix_out
);
	import rpf_pkg::*;

	mode_t                mode_q;
	logic [7:0]           factor_q;
	logic [CFG_DIM_W-1:0] fw_q, fh_q;
	logic [WD_W-1:0]      w_eff;
	logic [HT_W-1:0]      h_eff;

	logic  q_push, q_full, q_pop, q_vld;
	desc_t q_in, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NEGATIVE;
			factor_q <= '0;
			fw_q     <= CFG_DIM_W'(1);
			fh_q     <= CFG_DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:   mode_q   <= mode_t'(cfg_data[2:0]);
				REG_FACTOR: factor_q <= cfg_data[7:0];
				REG_WIDTH:  fw_q     <= cfg_data[CFG_DIM_W-1:0];
				REG_HEIGHT: fh_q     <= cfg_data[CFG_DIM_W-1:0];
			endcase
		end
	end

	// zero counts as one, oversize saturates
	always_comb begin
		if (fw_q == '0)
			w_eff = WD_W'(1);
		else if (32'(fw_q) > MAX_WIDTH)
			w_eff = WD_W'(MAX_WIDTH);
		else
			w_eff = WD_W'(fw_q);
		if (fh_q == '0)
			h_eff = HT_W'(1);
		else if (32'(fh_q) > MAX_HEIGHT)
			h_eff = HT_W'(MAX_HEIGHT);
		else
			h_eff = HT_W'(fh_q);
	end

	rpf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.w_eff  (w_eff),
		.h_eff  (h_eff),
		.q_full (q_full),
		.q_push (q_push),
		.q_desc (q_in)
	);

	rpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head_vld  (q_vld),
		.head_data (q_head)
	);

	rpf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_vld   (q_vld),
		.q_desc  (q_head),
		.q_pop   (q_pop),
		.mode    (mode_q),
		.factor  (factor_q),
		.pix_out (pix_out)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_vld)
		else $error("queue popped while empty");

	a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> q_vld)
		else $error("accepted beat missing from queue");

	a_stall_freezes_back: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && !pix_out.ready |-> !q_pop)
		else $error("pipeline advanced while output stalled");
endmodule
`default_nettype wire
